>>> rtl/bcsc_pkg.sv
package bcsc_pkg;

  // Sequencer states of the cull test
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_NEXT,
    ST_DONE
  } seq_state_e;

  // States of the shared divider
  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_CHECK,
    DIV_RUN,
    DIV_FIN
  } div_state_e;

  // Command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEST = 1'b1;

  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

endpackage

>>> rtl/bcsc_div.sv
module bcsc_div #(
  parameter int FracBits = 16,
  parameter int Cw       = 50
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [Cw-1:0] num_i,
  input  logic signed [Cw-1:0] den_i,
  output logic                 done_o,
  output logic [31:0]          quo_o
);

  localparam int Sh = 32 - FracBits;
  localparam int Wc = Cw + Sh;

  bcsc_pkg::div_state_e state_q, state_d;
  logic [Cw-1:0] a_q, b_q;
  logic          neg_q;
  logic [Cw-1:0] r_q;
  logic [31:0]   n_q, q_q;
  logic [4:0]    cnt_q;

  logic [Cw:0]   rs;
  logic          fits;
  logic [Wc-1:0] a_wide, b_wide;
  logic [31:0]   qc;

  // One restoring step per cycle
  always_comb begin
    rs   = {r_q, n_q[31]};
    fits = (rs >= {1'b0, b_q});
    if (fits) begin
      rs = rs - {1'b0, b_q};
    end
    a_wide = Wc'(a_q);
    b_wide = Wc'(b_q) << Sh;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bcsc_pkg::DIV_IDLE:  if (start_i) state_d = bcsc_pkg::DIV_CHECK;
      bcsc_pkg::DIV_CHECK: begin
        if (b_q == '0 || a_wide >= b_wide) state_d = bcsc_pkg::DIV_FIN;
        else state_d = bcsc_pkg::DIV_RUN;
      end
      bcsc_pkg::DIV_RUN:   if (cnt_q == '0) state_d = bcsc_pkg::DIV_FIN;
      bcsc_pkg::DIV_FIN:   state_d = bcsc_pkg::DIV_IDLE;
      default:             state_d = bcsc_pkg::DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bcsc_pkg::DIV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath: take magnitudes, check overflow, shift in quotient bits
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      bcsc_pkg::DIV_IDLE: begin
        if (start_i) begin
          a_q   <= num_i[Cw-1] ? Cw'(-num_i) : num_i;
          b_q   <= den_i[Cw-1] ? Cw'(-den_i) : den_i;
          neg_q <= num_i[Cw-1] ^ den_i[Cw-1];
        end
      end
      bcsc_pkg::DIV_CHECK: begin
        if (b_q == '0) begin
          q_q <= (a_q != '0) ? 32'h8000_0000 : 32'h0;
        end else if (a_wide >= b_wide) begin
          q_q <= 32'h8000_0000;
        end else begin
          r_q   <= a_q >> Sh;
          n_q   <= 32'({a_q, {FracBits{1'b0}}});
          q_q   <= '0;
          cnt_q <= 5'd31;
        end
      end
      bcsc_pkg::DIV_RUN: begin
        r_q   <= rs[Cw-1:0];
        n_q   <= {n_q[30:0], 1'b0};
        q_q   <= {q_q[30:0], fits};
        cnt_q <= cnt_q - 5'd1;
      end
      default: begin
      end
    endcase
  end

  // Saturate and apply sign
  always_comb begin
    qc = (q_q > 32'h8000_0000) ? 32'h8000_0000 : q_q;
    if (neg_q) quo_o = -qc;
    else if (qc == 32'h8000_0000) quo_o = bcsc_pkg::Q_MAX;
    else quo_o = qc;
  end

  assign done_o = (state_q == bcsc_pkg::DIV_FIN);

endmodule

>>> rtl/box_clip_space_cull_test_unit.sv
// Box clip-space cull test. A load beat (command 0) writes one entry of the
// 4x4 matrix and returns nothing. A test beat (command 1) runs the eight box
// corners through one shared 32x32 multiplier (16 matrix products per corner)
// and one shared radix-2 divider (three projected axes per corner); a division
// that saturates or divides by zero skips its bit-serial quotient loop.
// The input is stalled for the whole test; one result beat follows and is
// held until taken, and the next beat may be accepted meanwhile.
module box_clip_space_cull_test_unit #(
  parameter int FracBits = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [3:0]  entry_index_i,
  input  logic signed [31:0] entry_value_i,
  input  logic signed [31:0] box_min_x_i,
  input  logic signed [31:0] box_min_y_i,
  input  logic signed [31:0] box_min_z_i,
  input  logic signed [31:0] box_max_x_i,
  input  logic signed [31:0] box_max_y_i,
  input  logic signed [31:0] box_max_z_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        visible_o,
  output logic signed [31:0] screen_min_x_o,
  output logic signed [31:0] screen_min_y_o,
  output logic signed [31:0] screen_min_z_o,
  output logic signed [31:0] screen_max_x_o,
  output logic signed [31:0] screen_max_y_o,
  output logic signed [31:0] screen_max_z_o
);

  localparam int Cw = 66 - FracBits;
  localparam logic signed [31:0] One = 32'sd1 <<< FracBits;

  bcsc_pkg::seq_state_e state_q, state_d;

  logic signed [31:0] m_q [16];
  logic signed [31:0] lo_q [3];
  logic signed [31:0] hi_q [3];
  logic signed [31:0] mn_q [3];
  logic signed [31:0] mx_q [3];
  logic signed [Cw-1:0] clip_q [4];
  logic signed [63:0] prod_q;
  logic [3:0] k_q;
  logic [2:0] corner_q;
  logic [1:0] axis_q;

  logic in_acc, out_acc, div_start, div_done;
  logic [31:0] quo;
  logic signed [31:0] vsel, p;
  logic signed [Cw-1:0] term;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Select the vector element for the current column
  always_comb begin
    unique case (k_q[1:0])
      2'd0:    vsel = corner_q[0] ? lo_q[0] : hi_q[0];
      2'd1:    vsel = corner_q[1] ? lo_q[1] : hi_q[1];
      2'd2:    vsel = corner_q[2] ? lo_q[2] : hi_q[2];
      default: vsel = One;
    endcase
    term = Cw'(prod_q >>> FracBits);
    p    = $signed(quo);
  end

  bcsc_div #(.FracBits(FracBits), .Cw(Cw)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (clip_q[axis_q]),
    .den_i   (clip_q[3]),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bcsc_pkg::ST_IDLE:     if (in_acc && command_i == bcsc_pkg::CMD_TEST)
                               state_d = bcsc_pkg::ST_MUL;
      bcsc_pkg::ST_MUL:      state_d = bcsc_pkg::ST_ACC;
      bcsc_pkg::ST_ACC:      state_d = (k_q == 4'd15) ? bcsc_pkg::ST_DIV_GO
                                                      : bcsc_pkg::ST_MUL;
      bcsc_pkg::ST_DIV_GO:   state_d = bcsc_pkg::ST_DIV_WAIT;
      bcsc_pkg::ST_DIV_WAIT: begin
        if (div_done) state_d = (axis_q == 2'd2) ? bcsc_pkg::ST_NEXT
                                                 : bcsc_pkg::ST_DIV_GO;
      end
      bcsc_pkg::ST_NEXT:     state_d = (corner_q == 3'd7) ? bcsc_pkg::ST_DONE
                                                          : bcsc_pkg::ST_MUL;
      bcsc_pkg::ST_DONE:     if (!out_valid_o || !out_stall_i)
                               state_d = bcsc_pkg::ST_IDLE;
      default:               state_d = bcsc_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_stall_o = (state_q != bcsc_pkg::ST_IDLE);
    div_start  = (state_q == bcsc_pkg::ST_DIV_GO);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bcsc_pkg::ST_IDLE;
      out_valid_o <= 1'b0;
      for (int i = 0; i < 16; i++) m_q[i] <= '0;
    end else begin
      state_q <= state_d;
      // Write one matrix entry
      if (in_acc && command_i == bcsc_pkg::CMD_LOAD) m_q[entry_index_i] <= entry_value_i;
      // Drop the result once taken, raise it when the test ends
      if (state_q == bcsc_pkg::ST_DONE && state_d == bcsc_pkg::ST_IDLE) out_valid_o <= 1'b1;
      else if (out_acc) out_valid_o <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      bcsc_pkg::ST_IDLE: begin
        if (in_acc && command_i == bcsc_pkg::CMD_TEST) begin
          lo_q[0] <= box_min_x_i;  hi_q[0] <= box_max_x_i;
          lo_q[1] <= box_min_y_i;  hi_q[1] <= box_max_y_i;
          lo_q[2] <= box_min_z_i;  hi_q[2] <= box_max_z_i;
          for (int i = 0; i < 3; i++) begin
            mn_q[i] <= bcsc_pkg::Q_MAX;
            mx_q[i] <= bcsc_pkg::Q_MIN;
          end
          k_q      <= '0;
          corner_q <= '0;
        end
      end
      bcsc_pkg::ST_MUL: prod_q <= m_q[k_q] * vsel;
      bcsc_pkg::ST_ACC: begin
        if (k_q[1:0] == 2'd0) clip_q[k_q[3:2]] <= term;
        else clip_q[k_q[3:2]] <= clip_q[k_q[3:2]] + term;
        k_q <= k_q + 4'd1;
        axis_q <= '0;
      end
      bcsc_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          if (p < mn_q[axis_q]) mn_q[axis_q] <= p;
          if (p > mx_q[axis_q]) mx_q[axis_q] <= p;
          axis_q <= axis_q + 2'd1;
        end
      end
      bcsc_pkg::ST_NEXT: corner_q <= corner_q + 3'd1;
      bcsc_pkg::ST_DONE: begin
        if (!out_valid_o || !out_stall_i) begin
          visible_o <= !((mx_q[0] < -One) || (mn_q[0] > One) ||
                         (mx_q[1] < -One) || (mn_q[1] > One) ||
                         (mx_q[2] < -One) || (mn_q[2] > One));
          screen_min_x_o <= mn_q[0];
          screen_min_y_o <= mn_q[1];
          screen_min_z_o <= mn_q[2];
          screen_max_x_o <= mx_q[0];
          screen_max_y_o <= mx_q[1];
          screen_max_z_o <= mx_q[2];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/bcsc_chk.sv
module bcsc_chk #(
  parameter int FracBits = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        command_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        visible_o,
  input logic signed [31:0] screen_min_x_o,
  input logic signed [31:0] screen_min_y_o,
  input logic signed [31:0] screen_min_z_o,
  input logic signed [31:0] screen_max_x_o,
  input logic signed [31:0] screen_max_y_o,
  input logic signed [31:0] screen_max_z_o
);

  localparam logic signed [31:0] One = 32'sd1 <<< FracBits;

  // A test beat occupies the block
  a_test_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && command_i |=> in_stall_o)
    else $error("test beat did not stall input");

  // A load beat completes at once
  a_load_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !command_i |=> !in_stall_o)
    else $error("load beat stalled input");

  // Visibility agrees with the reported extent
  a_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> visible_o == !((screen_max_x_o < -One) || (screen_min_x_o > One) ||
                                   (screen_max_y_o < -One) || (screen_min_y_o > One) ||
                                   (screen_max_z_o < -One) || (screen_min_z_o > One)))
    else $error("visible flag disagrees with extent");

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(screen_min_x_o) &&
                                   $stable(screen_max_z_o) && $stable(visible_o))
    else $error("stalled result changed");

endmodule

bind box_clip_space_cull_test_unit bcsc_chk #(.FracBits(FracBits)) u_bcsc_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .command_i      (command_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .visible_o      (visible_o),
  .screen_min_x_o (screen_min_x_o),
  .screen_min_y_o (screen_min_y_o),
  .screen_min_z_o (screen_min_z_o),
  .screen_max_x_o (screen_max_x_o),
  .screen_max_y_o (screen_max_y_o),
  .screen_max_z_o (screen_max_z_o)
);
